// File: rtl/core/indexed_list_insert_remove_top_macros.svh
// Assertion macros shared by the indexed list RTL.
`ifndef INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ILIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list check failed");
// Next-cycle implication, checked out of reset.
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list check failed");
`else
`define ILIR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ilir_pkg.sv
// Types and constants for the indexed list block.
package ilir_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DATA_OUT_W  = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 3'd0,
    FN_INSERT   = 3'd1,
    FN_REM_LAST = 3'd2,
    FN_REM_AT   = 3'd3,
    FN_READ_AT  = 3'd4,
    FN_FIRST    = 3'd5,
    FN_LAST     = 3'd6,
    FN_CLEAR    = 3'd7
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// File: rtl/core/ilir_cell.sv
// One storage cell of the list row; shifts with its neighbors on insert and remove.
module ilir_cell #(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                  clk_i,
  input  ilir_pkg::cell_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]      sel_i,
  input  logic [DATA_BITS-1:0]  value_i,
  input  logic [DATA_BITS-1:0]  left_i,
  input  logic [DATA_BITS-1:0]  right_i,
  output logic [DATA_BITS-1:0]  word_o,
  output logic [DATA_BITS-1:0]  rd_o
);

  logic [DATA_BITS-1:0] word_q;
  logic [DATA_BITS-1:0] word_d;
  logic                 at_sel;
  logic                 past_sel;

  // Position of this cell relative to the selected index.
  assign at_sel   = (IDX_W'(IDX) == sel_i);
  assign past_sel = (IDX_W'(IDX) > sel_i);

  // Insert opens a gap at the selected cell; remove closes it from the right.
  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (at_sel) begin
        word_d = value_i;
      end else if (past_sel) begin
        word_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (at_sel || past_sel) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

  // Only the selected cell drives the shared read bus.
  assign rd_o = at_sel ? word_q : '0;

endmodule

// File: rtl/core/ilir_ctrl.sv
// Command decode, index clamping and entry count for the indexed list.
module ilir_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic [ilir_pkg::FUNC_W-1:0]       func_i,
  input  logic [ilir_pkg::POS_W-1:0]        position_i,
  output ilir_pkg::cell_ctl_t               ctl_o,
  output logic [$clog2(DEPTH)-1:0]          sel_o,
  output logic                              hit_o,
  output ilir_pkg::status_e                 status_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;

  logic [CW-1:0]       count_q;
  logic [CW-1:0]       count_d;
  logic [PW-1:0]       pos_w;
  logic [PW-1:0]       cnt_w;
  logic [PW-1:0]       last_w;
  logic [PW-1:0]       sel_w;
  logic                empty;
  logic                full;
  logic                ins;
  logic                rem;
  ilir_pkg::func_e     func;

  assign func   = ilir_pkg::func_e'(func_i);
  assign pos_w  = PW'(position_i);
  assign cnt_w  = PW'(count_q);
  assign last_w = cnt_w - PW'(1);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(DEPTH));

  // Decode the operation and clamp the index the way the list defines it.
  always_comb begin
    ins      = 1'b0;
    rem      = 1'b0;
    hit_o    = 1'b0;
    status_o = ilir_pkg::ST_OK;
    sel_w    = '0;
    count_d  = count_q;
    case (func)
      ilir_pkg::FN_APPEND, ilir_pkg::FN_INSERT: begin
        if (full) begin
          status_o = ilir_pkg::ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + CW'(1);
          if (func == ilir_pkg::FN_INSERT && pos_w < cnt_w) begin
            sel_w = pos_w;
          end else begin
            sel_w = cnt_w;
          end
        end
      end
      ilir_pkg::FN_REM_LAST, ilir_pkg::FN_REM_AT: begin
        if (empty) begin
          status_o = ilir_pkg::ST_EMPTY;
        end else begin
          rem     = 1'b1;
          hit_o   = 1'b1;
          count_d = count_q - CW'(1);
          if (func == ilir_pkg::FN_REM_AT && pos_w < last_w) begin
            sel_w = pos_w;
          end else begin
            sel_w = last_w;
          end
        end
      end
      ilir_pkg::FN_READ_AT: begin
        sel_w = pos_w;
        if (pos_w < cnt_w) begin
          hit_o = 1'b1;
        end else begin
          status_o = ilir_pkg::ST_EMPTY;
        end
      end
      ilir_pkg::FN_FIRST: begin
        if (empty) begin
          status_o = ilir_pkg::ST_EMPTY;
        end else begin
          hit_o = 1'b1;
        end
      end
      ilir_pkg::FN_LAST: begin
        sel_w = last_w;
        if (empty) begin
          status_o = ilir_pkg::ST_EMPTY;
        end else begin
          hit_o = 1'b1;
        end
      end
      ilir_pkg::FN_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Cells move only on an accepted command beat.
  assign ctl_o.ins = go_i && ins;
  assign ctl_o.rem = go_i && rem;
  assign sel_o     = sel_w[IW-1:0];

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (go_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

// File: rtl/core/indexed_list_insert_remove_top.sv
// Top level of the indexed list: a row of shifting cells with a registered result.
//
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------------
//  command  | start_i, busy_o      | func_i, position_i, value_i
//  result   | done_o (one cycle)   | data_out_o, hit_o, status_o, count_out_o
//
// One command beat is taken every clock; busy_o stays low.
// The result appears in the cycle after its command, for exactly one cycle.
// All cells shift in parallel in the accepting cycle; the read path is a select
// across the cell row, so every position is read through the same path.
// Reset clears the entry count and result strobe; cell contents are not reset.
// The receiver cannot stall, so nothing holds results back.
`include "indexed_list_insert_remove_top_macros.svh"

module indexed_list_insert_remove_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ilir_pkg::FUNC_W-1:0]         func_i,
  input  logic [ilir_pkg::POS_W-1:0]          position_i,
  input  logic [ilir_pkg::VALUE_W-1:0]        value_i,
  output logic                                done_o,
  output logic [ilir_pkg::DATA_OUT_W-1:0]     data_out_o,
  output logic                                hit_o,
  output logic [ilir_pkg::STATUS_W-1:0]       status_o,
  output logic [ilir_pkg::COUNT_OUT_W-1:0]    count_out_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned WW  = (DATA_BITS > ilir_pkg::VALUE_W) ? DATA_BITS : ilir_pkg::VALUE_W;
  localparam int unsigned KW  = (CW > ilir_pkg::COUNT_OUT_W) ? CW : ilir_pkg::COUNT_OUT_W;

  logic                                 go;
  ilir_pkg::cell_ctl_t                  ctl;
  logic [IW-1:0]                        sel;
  logic                                 hit;
  ilir_pkg::status_e                    status;
  logic [CW-1:0]                        count_next;
  logic [WW-1:0]                        value_ext;
  logic [DATA_BITS-1:0]                 word_in;
  logic [DATA_BITS-1:0]                 word   [DEPTH];
  logic [DATA_BITS-1:0]                 rd     [DEPTH];
  logic [DATA_BITS-1:0]                 rd_word;
  logic [WW-1:0]                        rd_ext;
  logic [KW-1:0]                        count_ext;

  logic                                 done_q;
  logic [ilir_pkg::DATA_OUT_W-1:0]      data_q;
  logic [ilir_pkg::DATA_OUT_W-1:0]      data_d;
  logic                                 hit_q;
  ilir_pkg::status_e                    status_q;
  logic [ilir_pkg::COUNT_OUT_W-1:0]     count_q;

  // Every command beat is taken.
  assign busy_o = 1'b0;
  assign go     = start_i && !busy_o;

  // Bring the data word to the stored width.
  assign value_ext = WW'(value_i);
  assign word_in   = value_ext[DATA_BITS-1:0];

  ilir_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .func_i     (func_i),
    .position_i (position_i),
    .ctl_o      (ctl),
    .sel_o      (sel),
    .hit_o      (hit),
    .status_o   (status),
    .count_o    (count_next)
  );

  // Row of cells, each wired to its neighbors; the first takes zero on the left, the last itself on the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_BITS-1:0] left;
    logic [DATA_BITS-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = word[i];
    end else begin : g_mid_r
      assign right = word[i+1];
    end
    ilir_cell #(
      .DATA_BITS(DATA_BITS),
      .IDX_W    (IW),
      .IDX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .sel_i  (sel),
      .value_i(word_in),
      .left_i (left),
      .right_i(right),
      .word_o (word[i]),
      .rd_o   (rd[i])
    );
  end

  // Collect the selected cell from the read bus.
  always_comb begin
    rd_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rd[i];
    end
  end

  assign rd_ext    = WW'(rd_word);
  assign data_d    = hit ? rd_ext[ilir_pkg::DATA_OUT_W-1:0] : '0;
  assign count_ext = KW'(count_next);

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= go;
    end
  end

  // Result payload, captured with its command beat.
  always_ff @(posedge clk_i) begin
    if (go) begin
      data_q   <= data_d;
      hit_q    <= hit;
      status_q <= status;
      count_q  <= count_ext[ilir_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign data_out_o  = data_q;
  assign hit_o       = hit_q;
  assign status_o    = status_q;
  assign count_out_o = count_q;

  // Each accepted command gives exactly one result in the next cycle.
  `ILIR_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, go, done_o)
  `ILIR_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !go, !done_o)
  // A result carrying an entry is always reported as ok.
  `ILIR_ASSERT_NOW(a_hit_ok, clk_i, rst_ni, done_o && hit_o, status_o == ilir_pkg::ST_OK)
  // A miss never shows data.
  `ILIR_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, done_o && !hit_o, data_out_o == '0)

endmodule
